// File: sv/lut_linear_interpolator_core_macros.svh
// Assertion macros shared by the interpolator modules.
// Depends on signals named clk and rst_n in the using module.
`ifndef LUT_LINEAR_INTERPOLATOR_CORE_MACROS_SVH
`define LUT_LINEAR_INTERPOLATOR_CORE_MACROS_SVH

// same-cycle implication
`define LLI_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lli: assertion failed");

// next-cycle implication
`define LLI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lli: assertion failed");

`endif

// File: sv/lli_pkg.sv
// Types, codes and defaults for the LUT linear interpolator.
// No dependencies.
package lli_pkg;

    localparam int MAX_BUCKETS_DEF = 256;

    localparam logic signed [31:0] DOM_BASE_RST     = 32'sd0;
    localparam logic [31:0]        BUCKET_SCALE_RST = 32'd65536;
    localparam logic [8:0]         BUCKET_COUNT_RST = 9'd256;

    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DOM_BASE     = 2'd0,
        REG_BUCKET_SCALE = 2'd1,
        REG_BUCKET_COUNT = 2'd2
    } lli_reg_t;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_EVAL  = 1'b1
    } lli_cmd_t;

    typedef enum logic [1:0] {
        CLAMP_NONE = 2'd0,
        CLAMP_LOW  = 2'd1,
        CLAMP_HIGH = 2'd2
    } lli_clamp_t;

    typedef struct packed {
        logic signed [31:0] dom_base;
        logic [31:0]        bucket_scale;
        logic [8:0]         bucket_count;
    } lli_cfg_t;

    // request leaving the table read, aligned with RAM read data
    typedef struct packed {
        logic       valid;
        lli_clamp_t code;
        logic [15:0] frac;
    } lli_tag_t;

endpackage

// File: sv/lut_linear_interpolator_core.sv
// LUT linear interpolator, top level. Depends on lli_pkg, lli_ram, lli_index, lli_blend.
// A request passes six register stages to a valid result. Throughput: one request per cycle
// while the output is not stalled; a single 32x32 multiply stage and a dual-read table RAM.
// Write requests store a table entry and give no result; output stall freezes the pipe.
// Reset clears valid bits, sets config defaults; table contents stay undefined until written.
module lut_linear_interpolator_core #(
    parameter int MAX_BUCKETS = lli_pkg::MAX_BUCKETS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [8:0]                       entry_index,
    input  logic signed [31:0]               entry_value,
    input  logic signed [31:0]               sample,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic signed [31:0]               value,
    output logic [1:0]                       clamp_code,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lli_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                      cfg_data
);
    import lli_pkg::*;

    localparam int DEPTH = MAX_BUCKETS + 1;
    localparam int AW    = $clog2(DEPTH);

    lli_cfg_t        cfg_reg;
    logic            en;
    logic            we;
    logic [AW-1:0]   waddr;
    logic [31:0]     wdata;
    logic [AW-1:0]   raddr_a;
    logic [AW-1:0]   raddr_b;
    logic [31:0]     rdata_a;
    logic [31:0]     rdata_b;
    lli_tag_t        tag;

    assign en        = !out_valid || out_ready;
    assign in_ready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dom_base     <= DOM_BASE_RST;
            cfg_reg.bucket_scale <= BUCKET_SCALE_RST;
            cfg_reg.bucket_count <= BUCKET_COUNT_RST;
        end
        else if (cfg_valid)
        begin
            unique case (lli_reg_t'(cfg_index))
                REG_DOM_BASE:     cfg_reg.dom_base     <= $signed(cfg_data);
                REG_BUCKET_SCALE: cfg_reg.bucket_scale <= cfg_data;
                REG_BUCKET_COUNT: cfg_reg.bucket_count <= cfg_data[8:0];
                default:          ;
            endcase
        end
    end

    lli_index #(
        .MAX_BUCKETS (MAX_BUCKETS),
        .AW          (AW)
    ) u_index (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (in_valid),
        .command     (command),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .sample      (sample),
        .cfg         (cfg_reg),
        .we          (we),
        .waddr       (waddr),
        .wdata       (wdata),
        .raddr_a     (raddr_a),
        .raddr_b     (raddr_b),
        .tag         (tag)
    );

    lli_ram #(
        .WIDTH   (32),
        .DEPTH   (DEPTH)
    ) u_table (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .re      (en),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    lli_blend u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .tag        (tag),
        .rdata_a    (rdata_a),
        .rdata_b    (rdata_b),
        .out_valid  (out_valid),
        .value      (value),
        .clamp_code (clamp_code)
    );

endmodule

// File: sv/lli_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module lli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// File: sv/lli_index.sv
// Front end: domain offset, bucket position multiply, clamp and table addressing.
// Depends on lli_pkg and the assertion macro header.
`include "lut_linear_interpolator_core_macros.svh"

module lli_index #(
    parameter int MAX_BUCKETS = lli_pkg::MAX_BUCKETS_DEF,
    parameter int AW          = $clog2(MAX_BUCKETS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic               command,
    input  logic [8:0]         entry_index,
    input  logic signed [31:0] entry_value,
    input  logic signed [31:0] sample,
    input  lli_pkg::lli_cfg_t  cfg,
    output logic               we,
    output logic [AW-1:0]      waddr,
    output logic [31:0]        wdata,
    output logic [AW-1:0]      raddr_a,
    output logic [AW-1:0]      raddr_b,
    output lli_pkg::lli_tag_t  tag
);
    import lli_pkg::*;

    localparam logic [31:0] MAX_B = 32'(MAX_BUCKETS);

    // stage 1
    logic               s1_valid_reg;
    lli_cmd_t           s1_cmd_reg;
    logic [8:0]         s1_index_reg;
    logic signed [31:0] s1_value_reg;
    logic signed [32:0] s1_d_reg;
    logic signed [32:0] s1_d_next;

    // stage 2
    logic               s2_valid_reg;
    lli_cmd_t           s2_cmd_reg;
    logic [8:0]         s2_index_reg;
    logic signed [31:0] s2_value_reg;
    logic [63:0]        s2_pos_reg;
    logic [63:0]        s2_pos_next;
    logic               s2_low_reg;
    logic               s2_low_next;

    // stage 3
    lli_tag_t           tag_reg;
    lli_tag_t           tag_next;

    logic [31:0]        cnt32;
    logic [31:0]        nb32;
    logic [31:0]        bucket;
    logic [31:0]        idx32;

    assign s1_d_next = 33'(sample) - 33'(cfg.dom_base);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            tag_reg      <= '0;
        end
        else if (en)
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            tag_reg      <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_cmd_reg   <= lli_cmd_t'(command);
            s1_index_reg <= entry_index;
            s1_value_reg <= entry_value;
            s1_d_reg     <= s1_d_next;
            s2_cmd_reg   <= s1_cmd_reg;
            s2_index_reg <= s1_index_reg;
            s2_value_reg <= s1_value_reg;
            s2_pos_reg   <= s2_pos_next;
            s2_low_reg   <= s2_low_next;
        end
    end

    // positive offsets fit in 32 bits
    assign s2_pos_next = s1_d_reg[31:0] * cfg.bucket_scale;
    assign s2_low_next = s1_d_reg[32] || (s1_d_reg == '0) || (cfg.bucket_scale == '0);

    always_comb
    begin
        cnt32 = 32'(cfg.bucket_count);
        if (cnt32 == '0)
        begin
            nb32 = 32'd1;
        end
        else if (cnt32 > MAX_B)
        begin
            nb32 = MAX_B;
        end
        else
        begin
            nb32 = cnt32;
        end
    end

    assign bucket = s2_pos_reg[63:32];

    always_comb
    begin
        tag_next.valid = s2_valid_reg && (s2_cmd_reg == CMD_EVAL);
        tag_next.frac  = s2_pos_reg[31:16];
        if (s2_low_reg)
        begin
            tag_next.code = CLAMP_LOW;
            raddr_a       = '0;
        end
        else if (bucket >= nb32)
        begin
            tag_next.code = CLAMP_HIGH;
            raddr_a       = nb32[AW-1:0];
        end
        else
        begin
            tag_next.code = CLAMP_NONE;
            raddr_a       = bucket[AW-1:0];
        end
        raddr_b = raddr_a + AW'(1);
    end

    assign idx32 = 32'(s2_index_reg);
    assign we    = en && s2_valid_reg && (s2_cmd_reg == CMD_WRITE) && (idx32 <= MAX_B);
    assign waddr = idx32[AW-1:0];
    assign wdata = s2_value_reg;
    assign tag   = tag_reg;

    `LLI_ASSERT_NEXT(a_eval_reaches_tag, en && s2_valid_reg && (s2_cmd_reg == CMD_EVAL),
        tag_reg.valid)
    `LLI_ASSERT_IMPL(a_interp_in_range, tag_next.valid && (tag_next.code == CLAMP_NONE),
        (32'(raddr_a) < nb32) && (32'(raddr_b) == 32'(raddr_a) + 32'd1))
    `LLI_ASSERT_IMPL(a_write_in_table, we, 32'(waddr) <= MAX_B)

endmodule

// File: sv/lli_blend.sv
// Back end: neighbor difference, fraction multiply, rounding and output register.
// Depends on lli_pkg and the assertion macro header.
`include "lut_linear_interpolator_core_macros.svh"

module lli_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  lli_pkg::lli_tag_t  tag,
    input  logic [31:0]        rdata_a,
    input  logic [31:0]        rdata_b,
    output logic               out_valid,
    output logic signed [31:0] value,
    output logic [1:0]         clamp_code
);
    import lli_pkg::*;

    // stage 4
    logic               s4_valid_reg;
    lli_clamp_t         s4_code_reg;
    logic [15:0]        s4_frac_reg;
    logic signed [31:0] s4_a_reg;
    logic signed [32:0] s4_diff_reg;
    logic signed [32:0] s4_diff_next;

    // stage 5
    logic               s5_valid_reg;
    lli_clamp_t         s5_code_reg;
    logic signed [31:0] s5_a_reg;
    logic signed [49:0] s5_prod_reg;
    logic signed [49:0] s5_prod_next;

    // output
    logic               out_valid_reg;
    lli_clamp_t         out_code_reg;
    logic signed [31:0] out_value_reg;
    logic signed [31:0] out_value_next;
    logic signed [50:0] round_sum;
    logic signed [50:0] round_shift;

    always_comb
    begin
        if (tag.code == CLAMP_NONE)
        begin
            s4_diff_next = 33'($signed(rdata_b)) - 33'($signed(rdata_a));
        end
        else
        begin
            s4_diff_next = '0;
        end
    end

    assign s5_prod_next = 50'($signed({1'b0, s4_frac_reg})) * 50'(s4_diff_reg);

    assign round_sum      = 51'(s5_prod_reg) + 51'sd32768;
    assign round_shift    = round_sum >>> 16;
    assign out_value_next = s5_a_reg + round_shift[31:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s4_valid_reg  <= tag.valid;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_code_reg   <= tag.code;
            s4_frac_reg   <= tag.frac;
            s4_a_reg      <= $signed(rdata_a);
            s4_diff_reg   <= s4_diff_next;
            s5_code_reg   <= s4_code_reg;
            s5_a_reg      <= s4_a_reg;
            s5_prod_reg   <= s5_prod_next;
            out_code_reg  <= s5_code_reg;
            out_value_reg <= out_value_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign value      = out_value_reg;
    assign clamp_code = out_code_reg;

    `LLI_ASSERT_IMPL(a_clamp_no_slope, s4_valid_reg && (s4_code_reg != CLAMP_NONE),
        s4_diff_reg == '0)
    `LLI_ASSERT_NEXT(a_stall_holds, !en, $stable(out_valid_reg) && $stable(out_value_reg))
    `LLI_ASSERT_NEXT(a_code_follows, en && s5_valid_reg,
        out_valid_reg && (out_code_reg == $past(s5_code_reg)))

endmodule

// File: verif/tb_lut_linear_interpolator_core.sv
// Self-checking testbench for lut_linear_interpolator_core: table loads, evaluations and
// register settings are predicted in a shadow of the table and checked result by result.
// Depends on lli_pkg and the core RTL.
module tb_lut_linear_interpolator_core;
    import lli_pkg::*;

    localparam int NB_MAX       = MAX_BUCKETS_DEF;
    localparam int PIPE_LATENCY = 6;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int IDLE_PCT     = 35;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

    typedef struct packed {
        logic signed [31:0] value;
        lli_clamp_t         code;
    } lookup_t;

    logic                     clk         = 1'b0;
    logic                     rst_n       = 1'b0;
    logic                     in_valid    = 1'b0;
    logic                     in_ready;
    logic                     command     = CMD_WRITE;
    logic [8:0]               entry_index = '0;
    logic signed [31:0]       entry_value = '0;
    logic signed [31:0]       sample      = '0;
    logic                     out_valid;
    logic                     out_ready   = 1'b0;
    logic signed [31:0]       value;
    logic [1:0]               clamp_code;
    logic                     cfg_valid   = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index   = '0;
    logic [31:0]              cfg_data    = '0;

    logic signed [31:0] lut_shadow [0:NB_MAX];
    logic signed [31:0] dom_lower = DOM_BASE_RST;
    logic [31:0]        bkt_scale = BUCKET_SCALE_RST;
    logic [8:0]         bkt_count = BUCKET_COUNT_RST;

    lookup_t     expected_results [$];
    int unsigned mismatch_count   = 0;
    bit          steady           = 1'b0;
    bit          hold_off_request = 1'b0;
    bit          hold_done        = 1'b0;

    lut_linear_interpolator_core #(.MAX_BUCKETS(NB_MAX)) DUT (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int unsigned used_buckets_now();
        int unsigned n;
        n = bkt_count;
        if (n < 1) n = 1;
        if (n > NB_MAX) n = NB_MAX;
        return n;
    endfunction

    function automatic lookup_t interpolate(logic signed [31:0] x);
        lookup_t     r;
        longint      d;
        longint      a;
        longint      b;
        longint      prod;
        logic [63:0] pos;
        int unsigned nb;
        nb = used_buckets_now();
        d  = longint'(x) - longint'(dom_lower);
        if (d <= 0 || bkt_scale == 0)
        begin
            r.value = lut_shadow[0];
            r.code  = CLAMP_LOW;
        end
        else
        begin
            pos = 64'(d) * 64'(bkt_scale);
            if (pos[63:32] >= nb)
            begin
                r.value = lut_shadow[nb];
                r.code  = CLAMP_HIGH;
            end
            else
            begin
                a       = lut_shadow[pos[63:32]];
                b       = lut_shadow[pos[63:32] + 1];
                prod    = longint'(pos[31:16]) * (b - a);
                r.value = 32'(a + ((prod + 32768) >>> 16));
                r.code  = CLAMP_NONE;
            end
        end
        return r;
    endfunction

    function automatic void absorb_request(lli_cmd_t cmd, logic [8:0] idx,
                                           logic signed [31:0] val, logic signed [31:0] x);
        if (cmd == CMD_WRITE)
        begin
            if (idx <= NB_MAX)
                lut_shadow[idx] = val;
        end
        else
            expected_results.push_back(interpolate(x));
    endfunction

    // mostly aim at a chosen bucket so the interpolating path is hit
    function automatic logic signed [31:0] pick_sample();
        longint target;
        longint s;
        if (bkt_scale == 0 || $urandom_range(99) < 20)
            return $urandom();
        target = (longint'($urandom_range(used_buckets_now())) << 32) | longint'($urandom());
        s = longint'(dom_lower) + target / longint'(bkt_scale);
        if (s > 64'sd2147483647)
            return $urandom();
        return s[31:0];
    endfunction

    task automatic send_request(lli_cmd_t cmd, logic [8:0] idx,
                                logic signed [31:0] val, logic signed [31:0] x);
        if (!steady)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        entry_index <= idx;
        entry_value <= val;
        sample      <= x;
        do @(posedge clk); while (!in_ready);
        absorb_request(cmd, idx, val, x);
    endtask

    task automatic write_entry(logic [8:0] idx, logic signed [31:0] val);
        send_request(CMD_WRITE, idx, val, $urandom());
    endtask

    task automatic eval_at(logic signed [31:0] x);
        send_request(CMD_EVAL, 9'($urandom()), $urandom(), x);
    endtask

    task automatic settle();
        int unsigned waited;
        waited = 0;
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_DOM_BASE:     dom_lower = data;
            REG_BUCKET_SCALE: bkt_scale = data;
            REG_BUCKET_COUNT: bkt_count = data[8:0];
            default: ;
        endcase
    endtask

    task automatic configure(logic signed [31:0] dom, logic [31:0] scale, logic [8:0] count,
                             bit poke_unused = 1'b0);
        settle();
        if (poke_unused)
            set_register(REG_UNUSED, $urandom());
        set_register(REG_DOM_BASE, dom);
        set_register(REG_BUCKET_SCALE, scale);
        set_register(REG_BUCKET_COUNT, {23'($urandom()), count});
        cfg_valid <= 1'b0;
    endtask

    task automatic test_table_load();
        for (int i = 0; i <= NB_MAX; i++)
            write_entry(9'(i), $urandom());
    endtask

    task automatic test_directed_defaults();
        write_entry(9'd0, 32'sh7FFF_FFFF);
        write_entry(9'd1, 32'sh8000_0000);
        eval_at(32'sh0000_8000);
        write_entry(9'd2, 32'sd0);
        write_entry(9'd3, 32'sd1);
        write_entry(9'd4, 32'sd0);
        write_entry(9'd5, -32'sd1);
        eval_at(32'sh0002_8000);
        eval_at(32'sh0003_8000);
        eval_at(32'sh0004_8000);
        eval_at(32'sd0);
        eval_at(32'sh8000_0000);
        eval_at(-32'sd1);
        eval_at(32'sd1);
        eval_at(32'sh0001_0000);
        eval_at(32'sh00FF_FFFF);
        eval_at(32'sh0100_0000);
        eval_at(32'sh7FFF_FFFF);
        // writes past the table end are dropped
        write_entry(9'd257, $urandom());
        write_entry(9'd511, $urandom());
        eval_at(32'sh7FFF_FFFF);
    endtask

    task automatic test_register_extremes();
        configure(32'sh8000_0000, 32'hFFFF_FFFF, 9'd0, 1'b1);
        repeat (8) eval_at(pick_sample());
        eval_at(32'sh7FFF_FFFF);
        eval_at(32'sh8000_0000);
        configure(32'sh7FFF_FFFF, 32'h0000_0001, 9'h1FF);
        repeat (6) eval_at(pick_sample());
        configure(32'sd0, 32'h0000_0000, 9'd256);
        repeat (6) eval_at(pick_sample());
        configure(32'shFFFF_0000, 32'h0002_0000, 9'd1);
        repeat (8) eval_at(pick_sample());
    endtask

    task automatic test_random_traffic();
        logic signed [31:0] dom;
        logic [31:0]        scale;
        logic [8:0]         count;
        for (int phase = 0; phase < 5; phase++)
        begin
            dom   = $urandom();
            dom   = dom >>> $urandom_range(0, 12);
            scale = $urandom() >> $urandom_range(0, 24);
            count = (phase == 2) ? 9'd256 : 9'($urandom_range(1, 256));
            configure(dom, scale, count);
            steady = (phase == 0);
            for (int n = 0; n < 55; n++)
            begin
                if ($urandom_range(99) < 20)
                    write_entry(($urandom_range(9) == 0) ? 9'($urandom_range(257, 511))
                                                         : 9'($urandom_range(0, NB_MAX)),
                                $urandom());
                else
                    eval_at(pick_sample());
            end
            steady = 1'b0;
        end
    endtask

    task automatic test_backpressure();
        configure(32'sd0, ONE_Q16, 9'd256);
        steady = 1'b1;
        hold_off_request = 1'b1;
        repeat (80) eval_at(pick_sample());
        steady = 1'b0;
    endtask

    // receiver side: random ready, with one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_off_request && !hold_done)
            begin
                hold_done = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin : result_check
        lookup_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("ERROR: unexpected result value=%h code=%0d", value, clamp_code);
            end
            else
            begin
                want = expected_results.pop_front();
                if (value !== want.value || clamp_code !== want.code)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("ERROR: expected value=%h code=%0d, got value=%h code=%0d",
                                 want.value, want.code, value, clamp_code);
                end
            end
        end
    end

    initial
    begin
        #(8 * 600_000);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_directed_defaults();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();
        settle();
        if (expected_results.size() != 0)
        begin
            mismatch_count++;
            $display("ERROR: %0d results never arrived", expected_results.size());
        end
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

// File: lut_linear_interpolator_core.f
+incdir+sv
sv/lli_pkg.sv
sv/lli_ram.sv
sv/lli_index.sv
sv/lli_blend.sv
sv/lut_linear_interpolator_core.sv
verif/tb_lut_linear_interpolator_core.sv
